@@ design/mad_pkg.sv @@
// mad_pkg: shared types, codes and constants of the motion accumulator.
// Used by every module of the motion_accumulate_to_direction_key block.
package mad_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ThreshW  = 15;
  localparam int unsigned SumW     = 16;

  localparam logic [CfgIdxW-1:0] REG_AXIS_SWAP   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOCK_EVENTS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD_X = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS  = 3'd4;

  localparam logic               RST_AXIS_SWAP   = 1'b1;
  localparam logic               RST_LOCK_EVENTS = 1'b0;
  localparam logic [ThreshW-1:0] RST_THRESHOLD   = 15'd10;
  localparam logic [15:0]        RST_HOLD_TICKS  = 16'd500;

  localparam int unsigned  MotionBit  = 7;
  localparam logic [7:0]   DELTA_NONE = 8'h60;

  typedef enum logic [1:0] {
    OP_MOTION = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef struct packed {
    logic               axis_swap;
    logic               lock_events;
    logic [ThreshW-1:0] threshold_x;
    logic [ThreshW-1:0] threshold_y;
    logic [15:0]        hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] motion_status;
    logic [7:0] delta_first;
    logic [7:0] delta_second;
  } item_t;

  typedef struct packed {
    logic            key_valid;
    logic [1:0]      key_direction;
    logic            activity_flag;
    logic [SumW-1:0] total_x;
    logic [SumW-1:0] total_y;
  } result_t;

  typedef struct packed {
    logic [SumW-1:0] accum_x;
    logic [SumW-1:0] accum_y;
    logic [7:0]      last_motion;
    logic            last_motion_known;
    logic            activity;
    logic [15:0]     hold_count;
    logic            hold_running;
  } state_t;

endpackage

@@ design/mad_if.sv @@
// mad_if: valid/ready channel interfaces for items, results and register writes.
// Depends on mad_pkg for widths.
interface mad_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] motion_status;
  logic [7:0] delta_first;
  logic [7:0] delta_second;

  modport source (output valid, opcode, motion_status, delta_first, delta_second,
                  input ready);
  modport sink   (input valid, opcode, motion_status, delta_first, delta_second,
                  output ready);
endinterface

interface mad_result_if;
  logic                              valid;
  logic                              ready;
  logic                              key_valid;
  logic [1:0]                        key_direction;
  logic                              activity_flag;
  logic signed [mad_pkg::SumW-1:0]   total_x;
  logic signed [mad_pkg::SumW-1:0]   total_y;

  modport source (output valid, key_valid, key_direction, activity_flag, total_x, total_y,
                  input ready);
  modport sink   (input valid, key_valid, key_direction, activity_flag, total_x, total_y,
                  output ready);
endinterface

interface mad_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mad_pkg::CfgIdxW-1:0]      index;
  logic [mad_pkg::CfgDataW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/mad_cfg.sv @@
// mad_cfg: configuration register file, written through the cfg channel.
// Depends on mad_pkg and mad_cfg_if.
module mad_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  mad_cfg_if.sink       cfg_i,
  output mad_pkg::cfg_t cfg_o
);

  mad_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mad_pkg::REG_AXIS_SWAP:   cfg_d.axis_swap   = cfg_i.data[0];
        mad_pkg::REG_LOCK_EVENTS: cfg_d.lock_events = cfg_i.data[0];
        mad_pkg::REG_THRESHOLD_X: cfg_d.threshold_x = cfg_i.data[mad_pkg::ThreshW-1:0];
        mad_pkg::REG_THRESHOLD_Y: cfg_d.threshold_y = cfg_i.data[mad_pkg::ThreshW-1:0];
        mad_pkg::REG_HOLD_TICKS:  cfg_d.hold_ticks  = cfg_i.data[15:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_swap   <= mad_pkg::RST_AXIS_SWAP;
      cfg_q.lock_events <= mad_pkg::RST_LOCK_EVENTS;
      cfg_q.threshold_x <= mad_pkg::RST_THRESHOLD;
      cfg_q.threshold_y <= mad_pkg::RST_THRESHOLD;
      cfg_q.hold_ticks  <= mad_pkg::RST_HOLD_TICKS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/mad_step.sv @@
// mad_step: per-word update of sums, motion memory, hold timer and activity flag.
// Purely combinational; depends on mad_pkg.
module mad_step (
  input  mad_pkg::cfg_t    cfg_i,
  input  mad_pkg::item_t   item_i,
  input  mad_pkg::state_t  st_i,
  output mad_pkg::state_t  st_o,
  output mad_pkg::result_t res_o
);

  logic        sample_ok;
  logic        motion_new;
  logic [7:0]  first, second, dx, dy;
  logic [15:0] sum_x, sum_y;
  logic signed [16:0] sx, sy, tx, ty;
  logic        key;
  mad_pkg::dir_e dir;

  assign first     = (item_i.delta_first  == mad_pkg::DELTA_NONE) ? 8'd0 : item_i.delta_first;
  assign second    = (item_i.delta_second == mad_pkg::DELTA_NONE) ? 8'd0 : item_i.delta_second;
  assign dx        = cfg_i.axis_swap ? second : first;
  assign dy        = cfg_i.axis_swap ? first  : 8'(8'd0 - second);
  assign sum_x     = st_i.accum_x + {{8{dx[7]}}, dx};
  assign sum_y     = st_i.accum_y + {{8{dy[7]}}, dy};
  assign sx        = $signed({sum_x[15], sum_x});
  assign sy        = $signed({sum_y[15], sum_y});
  assign tx        = $signed({2'b00, cfg_i.threshold_x});
  assign ty        = $signed({2'b00, cfg_i.threshold_y});
  assign sample_ok = item_i.motion_status[mad_pkg::MotionBit] && !cfg_i.lock_events;
  assign motion_new = !st_i.last_motion_known || (st_i.last_motion != item_i.motion_status);

  always_comb begin
    key = 1'b1;
    dir = mad_pkg::DIR_DOWN;
    priority if (sx > tx) begin
      dir = mad_pkg::DIR_DOWN;
    end else if (sx < -tx) begin
      dir = mad_pkg::DIR_UP;
    end else if (sy > ty) begin
      dir = mad_pkg::DIR_LEFT;
    end else if (sy < -ty) begin
      dir = mad_pkg::DIR_RIGHT;
    end else begin
      key = 1'b0;
    end
  end

  always_comb begin
    st_o                    = st_i;
    res_o.key_valid         = 1'b0;
    res_o.key_direction     = mad_pkg::DIR_DOWN;
    res_o.activity_flag     = st_i.activity;
    unique case (mad_pkg::op_e'(item_i.opcode))
      mad_pkg::OP_MOTION: begin
        st_o.last_motion       = item_i.motion_status;
        st_o.last_motion_known = 1'b1;
        if (sample_ok) begin
          if (key) begin
            st_o.accum_x = '0;
            st_o.accum_y = '0;
          end else begin
            st_o.accum_x = sum_x;
            st_o.accum_y = sum_y;
          end
          if (key || motion_new) begin
            st_o.activity     = 1'b1;
            st_o.hold_count   = cfg_i.hold_ticks;
            st_o.hold_running = 1'b1;
          end
          res_o.key_valid     = key;
          res_o.key_direction = key ? dir : mad_pkg::DIR_DOWN;
        end
        res_o.activity_flag = st_o.activity;
      end
      mad_pkg::OP_TICK: begin
        if (st_i.hold_running) begin
          if (st_i.hold_count <= 16'd1) begin
            st_o.hold_count   = '0;
            st_o.hold_running = 1'b0;
            st_o.activity     = 1'b0;
          end else begin
            st_o.hold_count = st_i.hold_count - 16'd1;
          end
        end
        res_o.activity_flag = st_o.activity;
      end
      mad_pkg::OP_READ: begin
        st_o.activity = 1'b0;
      end
      default: begin
        st_o = st_i;
      end
    endcase
    res_o.total_x = st_o.accum_x;
    res_o.total_y = st_o.accum_y;
  end

endmodule

@@ design/motion_accumulate_to_direction_key.sv @@
// motion_accumulate_to_direction_key: top level, input and result registers, state.
// Depends on mad_pkg, mad_if, mad_cfg and mad_step.
//
//   channel   | dir | words carried
//   ----------+-----+------------------------------------------------------------
//   item_i    | in  | opcode, motion_status, delta_first, delta_second
//   result_o  | out | key_valid, key_direction, activity_flag, total_x, total_y
//   cfg_i     | in  | index, data (register write, always ready)
//
// One word per cycle sustained while the result is not stalled; an accepted item passes the
// input register and is then held as a valid result in the result register.
// The state update happens as a word moves from the input register to the result register.
// rst_ni clears the pipeline valids, the state and loads the register reset values.
// A stalled result holds; the input register still takes a word while it is empty, or while
// the result is free or being taken in the same cycle.
module motion_accumulate_to_direction_key (
  input  logic          clk_i,
  input  logic          rst_ni,
  mad_item_if.sink      item_i,
  mad_result_if.source  result_o,
  mad_cfg_if.sink       cfg_i
);

  mad_pkg::cfg_t    cfg;
  mad_pkg::item_t   item_q;
  mad_pkg::state_t  st_q, st_d;
  mad_pkg::result_t res_q, res_d;
  logic             in_vld_q, out_vld_q;
  logic             adv, in_rdy;

  mad_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mad_step u_step (
    .cfg_i  (cfg),
    .item_i (item_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign adv          = in_vld_q && (!out_vld_q || result_o.ready);
  assign in_rdy       = !in_vld_q || adv;
  assign item_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (in_rdy) begin
        in_vld_q <= item_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && item_i.valid) begin
      item_q.opcode        <= item_i.opcode;
      item_q.motion_status <= item_i.motion_status;
      item_q.delta_first   <= item_i.delta_first;
      item_q.delta_second  <= item_i.delta_second;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.key_valid     = res_q.key_valid;
  assign result_o.key_direction = res_q.key_direction;
  assign result_o.activity_flag = res_q.activity_flag;
  assign result_o.total_x       = $signed(res_q.total_x);
  assign result_o.total_y       = $signed(res_q.total_y);

endmodule

@@ design/mad_checker.sv @@
// mad_checker: port-level assertions on the result channel of the block.
// Bound to motion_accumulate_to_direction_key; depends on mad_pkg.
module mad_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic                        key_valid_i,
  input logic [1:0]                  key_direction_i,
  input logic                        activity_flag_i,
  input logic [mad_pkg::SumW-1:0]    total_x_i,
  input logic [mad_pkg::SumW-1:0]    total_y_i
);

  // no key, direction reads as down
  a_dir_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !key_valid_i) |-> (key_direction_i == mad_pkg::DIR_DOWN))
    else $error("direction set without key");

  // key clears both sums
  a_key_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && key_valid_i) |-> (total_x_i == '0 && total_y_i == '0))
    else $error("sums not cleared on key");

  // key re-arms the flag
  a_key_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && key_valid_i) |-> activity_flag_i)
    else $error("flag low on key");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(key_valid_i)
                                       && $stable(total_x_i) && $stable(total_y_i)
                                       && $stable(activity_flag_i)))
    else $error("result word changed under stall");

endmodule

bind motion_accumulate_to_direction_key mad_checker u_mad_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (result_o.valid),
  .res_ready_i     (result_o.ready),
  .key_valid_i     (result_o.key_valid),
  .key_direction_i (result_o.key_direction),
  .activity_flag_i (result_o.activity_flag),
  .total_x_i       (result_o.total_x),
  .total_y_i       (result_o.total_y)
);
